// File: src/sbfr_pkg.sv
// Package for the bus servo frame receiver.
// Holds the frame constants and the result struct. No dependencies.
`default_nettype none

package sbfr_pkg;

	localparam logic [7:0] HDR_BYTE = 8'h55;
	localparam logic [7:0] LEN_MIN  = 8'd3;
	localparam logic [7:0] LEN_MAX  = 8'd7;

	// position 0 id, 1 length, 2 command, 3..6 params, up to 7 checksum
	localparam int POS_W    = 3;
	localparam int N_PARAMS = 4;

	typedef logic [POS_W-1:0] pos_t;

	typedef struct packed {
		logic [7:0] servo_id;
		logic [7:0] command;
		logic [2:0] param_count;
		logic [7:0] param0;
		logic [7:0] param1;
		logic [7:0] param2;
		logic [7:0] param3;
		logic       checksum_ok;
	} frame_t;

endpackage

`default_nettype wire

// File: src/sbfr_byte_if.sv
// Byte channel: valid/ready handshake carrying one received byte.
// No dependencies.
`default_nettype none

interface sbfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: src/sbfr_frame_if.sv
// Frame result channel: valid/ready handshake carrying one parsed frame.
// No dependencies.
`default_nettype none

interface sbfr_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] servo_id;
	logic [7:0] command;
	logic [2:0] param_count;
	logic [7:0] param0;
	logic [7:0] param1;
	logic [7:0] param2;
	logic [7:0] param3;
	logic       checksum_ok;

	modport source (output valid, output servo_id, output command, output param_count,
		output param0, output param1, output param2, output param3,
		output checksum_ok, input ready);
	modport sink (input valid, input servo_id, input command, input param_count,
		input param0, input param1, input param2, input param3,
		input checksum_ok, output ready);
endinterface

`default_nettype wire

// File: src/sbfr_parser.sv
// Frame parser: header hunt, field capture and running checksum.
// Uses sbfr_pkg.
`default_nettype none

module sbfr_parser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            go,
	input  wire logic [7:0]      rx_byte,
	output logic                 res_valid,
	output sbfr_pkg::frame_t     res
);

	logic             header_seen_q, header_seen_d;
	logic             in_frame_q, in_frame_d;
	sbfr_pkg::pos_t   pos_q, pos_d;
	logic [2:0]       flen_q, flen_d;
	logic [7:0]       id_q, id_d;
	logic [7:0]       cmd_q, cmd_d;
	logic [7:0]       sum_q, sum_d;
	logic [7:0]       param_q [sbfr_pkg::N_PARAMS];
	logic [7:0]       param_d [sbfr_pkg::N_PARAMS];
	logic [7:0]       sum_add;
	sbfr_pkg::pos_t   pidx;

	assign sum_add = sum_q + rx_byte;
	assign pidx    = pos_q - sbfr_pkg::pos_t'(sbfr_pkg::LEN_MIN);

	// result fields come from the held frame; checksum_ok tests the current byte against it
	always_comb begin
		res.servo_id    = id_q;
		res.command     = cmd_q;
		res.param_count = flen_q - sbfr_pkg::LEN_MIN[2:0];
		res.param0      = param_q[0];
		res.param1      = param_q[1];
		res.param2      = param_q[2];
		res.param3      = param_q[3];
		res.checksum_ok = (~sum_q == rx_byte);
	end

	always_comb begin
		header_seen_d = header_seen_q;
		in_frame_d    = in_frame_q;
		pos_d         = pos_q;
		flen_d        = flen_q;
		id_d          = id_q;
		cmd_d         = cmd_q;
		sum_d         = sum_q;
		param_d       = param_q;
		res_valid     = 1'b0;
		if (go) begin
			if (!in_frame_q) begin
				if (rx_byte == sbfr_pkg::HDR_BYTE) begin
					if (header_seen_q) begin
						header_seen_d = 1'b0;
						in_frame_d    = 1'b1;
						pos_d         = '0;
						sum_d         = '0;
						id_d          = '0;
						cmd_d         = '0;
						for (int i = 0; i < sbfr_pkg::N_PARAMS; i++) param_d[i] = '0;
					end else begin
						header_seen_d = 1'b1;
					end
				end else begin
					header_seen_d = 1'b0;
				end
			end else if (pos_q == sbfr_pkg::pos_t'(0)) begin
				id_d  = rx_byte;
				sum_d = sum_add;
				pos_d = sbfr_pkg::pos_t'(1);
			end else if (pos_q == sbfr_pkg::pos_t'(1)) begin
				if (rx_byte < sbfr_pkg::LEN_MIN || rx_byte > sbfr_pkg::LEN_MAX) begin
					in_frame_d    = 1'b0;
					header_seen_d = 1'b0;
					pos_d         = '0;
				end else begin
					flen_d = rx_byte[2:0];
					sum_d  = sum_add;
					pos_d  = sbfr_pkg::pos_t'(2);
				end
			end else if (pos_q < flen_q) begin
				if (pos_q == sbfr_pkg::pos_t'(2)) begin
					cmd_d = rx_byte;
				end else begin
					for (int i = 0; i < sbfr_pkg::N_PARAMS; i++)
						if (pidx == sbfr_pkg::pos_t'(i)) param_d[i] = rx_byte;
				end
				sum_d = sum_add;
				pos_d = pos_q + sbfr_pkg::pos_t'(1);
			end else begin
				// checksum byte closes the frame
				res_valid     = 1'b1;
				in_frame_d    = 1'b0;
				header_seen_d = 1'b0;
				pos_d         = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_seen_q <= 1'b0;
			in_frame_q    <= 1'b0;
			pos_q         <= '0;
			flen_q        <= '0;
		end else begin
			header_seen_q <= header_seen_d;
			in_frame_q    <= in_frame_d;
			pos_q         <= pos_d;
			flen_q        <= flen_d;
		end
	end

	// frame contents are cleared on every header pair before use
	always_ff @(posedge clk) begin
		id_q    <= id_d;
		cmd_q   <= cmd_d;
		sum_q   <= sum_d;
		param_q <= param_d;
	end

endmodule

`default_nettype wire

// File: src/sbfr_out_reg.sv
// Result register driving the frame channel.
// Uses sbfr_pkg and sbfr_frame_if.
`default_nettype none

module sbfr_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire sbfr_pkg::frame_t res,
	sbfr_frame_if.source          frame
);

	logic             valid_q;
	sbfr_pkg::frame_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (frame.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign frame.valid       = valid_q;
	assign frame.servo_id    = data_q.servo_id;
	assign frame.command     = data_q.command;
	assign frame.param_count = data_q.param_count;
	assign frame.param0      = data_q.param0;
	assign frame.param1      = data_q.param1;
	assign frame.param2      = data_q.param2;
	assign frame.param3      = data_q.param3;
	assign frame.checksum_ok = data_q.checksum_ok;

endmodule

`default_nettype wire

// File: src/servo_bus_frame_receiver.sv
// Top level of the bus servo frame receiver.
// Uses sbfr_pkg, sbfr_byte_if, sbfr_frame_if, sbfr_parser and sbfr_out_reg.
`default_nettype none

// Takes one received serial byte per request on rx and returns one parsed
// frame per request on frame. A frame is two 0x55 header bytes, id, length
// (3..7), command, length-3 parameter bytes and a checksum byte equal to the
// inverted low byte of id+length+command+params. A bad length drops the
// frame silently and restarts the header hunt; a bad checksum still returns
// the frame with checksum_ok low. Absent parameters read as zero.
// Throughput is one byte per cycle unless the frame channel stalls.
// An accepted byte is held in the input register, then passes through the
// parser into the result register, which drives the frame channel. The input
// register only advances while the result register is empty or being
// taken, so a stalled frame channel backs up to rx after one byte.

module servo_bus_frame_receiver (
	input  wire logic    clk,
	input  wire logic    arst_n,
	sbfr_byte_if.sink    rx,
	sbfr_frame_if.source frame
);

	logic             valid_s1;
	logic [7:0]       rx_byte_s1;
	logic             advance;
	logic             go;
	logic             res_valid;
	sbfr_pkg::frame_t res;

	// stage 1 may move when the result slot is free or draining
	assign advance  = !frame.valid || frame.ready;
	assign rx.ready = !valid_s1 || advance;
	assign go       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	sbfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.rx_byte   (rx_byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// a result only appears when go, so the slot is free or draining here
	sbfr_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_valid),
		.res    (res),
		.frame  (frame)
	);

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Testbench for servo_bus_frame_receiver: drives received bytes on rx and checks
// every parsed frame on the frame channel against an in-bench frame tracker.
// Depends on sbfr_pkg, sbfr_byte_if, sbfr_frame_if and the receiver RTL.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;

	sbfr_byte_if  rx_if ();
	sbfr_frame_if frame_if ();

	servo_bus_frame_receiver dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.frame  (frame_if)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// frames the tracker says must come out, oldest first
	sbfr_pkg::frame_t pending_frames[$];

	// tracker state: mirrors the receiver's hunt / collect machine
	logic            hunt_half;   // one 0x55 seen while hunting
	logic            collecting;  // both headers seen
	logic [3:0]      pos;         // 0 id, 1 length, 2 command, 3.. params
	logic [2:0]      flen;
	logic [7:0]      h_id;
	logic [7:0]      h_cmd;
	logic [7:0]      h_sum;
	logic [3:0][7:0] h_prm;

	// traffic shaping knobs, flipped by the tests
	bit src_gaps;
	bit sink_stalls;
	int stall_left;

	int errors;
	int bytes_sent;
	int frames_checked;
	int bad_sum_frames;

	// Mostly short holes, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic int pick_stall();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Advance the tracker by one accepted byte; queue a frame on the checksum byte.
	function automatic void track_frame_byte(input logic [7:0] b);
		sbfr_pkg::frame_t res;
		if (!collecting) begin
			if (b == sbfr_pkg::HDR_BYTE) begin
				if (hunt_half) begin
					// second header: fresh frame, all fields cleared
					hunt_half  = 1'b0;
					collecting = 1'b1;
					pos        = '0;
					h_sum      = '0;
					h_id       = '0;
					h_cmd      = '0;
					h_prm      = '0;
				end else begin
					hunt_half = 1'b1;
				end
			end else begin
				hunt_half = 1'b0;
			end
		end else if (pos == 4'd0) begin
			h_id  = b;
			h_sum = h_sum + b;
			pos   = 4'd1;
		end else if (pos == 4'd1) begin
			if (b < sbfr_pkg::LEN_MIN || b > sbfr_pkg::LEN_MAX) begin
				// bad length: drop silently, hunt from scratch
				collecting = 1'b0;
				hunt_half  = 1'b0;
				pos        = '0;
			end else begin
				flen  = b[2:0];
				h_sum = h_sum + b;
				pos   = 4'd2;
			end
		end else if (pos < {1'b0, flen}) begin
			if (pos == 4'd2)
				h_cmd = b;
			else
				h_prm[2'(pos - 4'd3)] = b;
			h_sum = h_sum + b;
			pos   = pos + 4'd1;
		end else begin
			res.servo_id    = h_id;
			res.command     = h_cmd;
			res.param_count = flen - 3'(sbfr_pkg::LEN_MIN);
			res.param0      = h_prm[0];
			res.param1      = h_prm[1];
			res.param2      = h_prm[2];
			res.param3      = h_prm[3];
			res.checksum_ok = (~h_sum == b);
			pending_frames.push_back(res);
			collecting = 1'b0;
			hunt_half  = 1'b0;
			pos        = '0;
		end
	endfunction

	// One byte request on rx; the tracker sees it at the accepting edge.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		do
			@(posedge clk);
		while (!rx_if.ready);
		track_frame_byte(b);
		bytes_sent++;
		gap = src_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Header, id, length; then, for a legal length, command, params and checksum.
	task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
		input logic [7:0] cmd, input logic [3:0][7:0] prm, input bit corrupt);
		logic [7:0] sum;
		int n;
		send_byte(sbfr_pkg::HDR_BYTE);
		send_byte(sbfr_pkg::HDR_BYTE);
		send_byte(id);
		send_byte(len);
		if (len < sbfr_pkg::LEN_MIN || len > sbfr_pkg::LEN_MAX)
			return;
		sum = id + len + cmd;
		send_byte(cmd);
		for (n = 0; n < int'(len - sbfr_pkg::LEN_MIN); n++) begin
			send_byte(prm[n]);
			sum = sum + prm[n];
		end
		if (corrupt)
			send_byte(~sum ^ 8'($urandom_range(1, 255)));
		else
			send_byte(~sum);
	endtask

	task automatic send_random_frame(input bit len_ok);
		logic [7:0] len;
		if (len_ok)
			len = 8'($urandom_range(sbfr_pkg::LEN_MIN, sbfr_pkg::LEN_MAX));
		else if ($urandom_range(0, 1))
			len = 8'($urandom_range(0, sbfr_pkg::LEN_MIN - 1));
		else
			len = 8'($urandom_range(sbfr_pkg::LEN_MAX + 1, 255));
		send_frame(8'($urandom), len, 8'($urandom), {$urandom}, $urandom_range(0, 99) < 15);
	endtask

	// Sender goes quiet until every queued frame has been seen.
	task automatic drain_results();
		rx_if.valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Frame sink: random stalls on ready, off when sink_stalls is clear.
	always @(posedge clk) begin
		if (sink_stalls && stall_left == 0 && $urandom_range(0, 99) < 20)
			stall_left = pick_stall();
		if (stall_left > 0) begin
			frame_if.ready <= 1'b0;
			stall_left--;
		end else begin
			frame_if.ready <= 1'b1;
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %02h, got %02h", name, want, got);
			errors++;
		end
	endfunction

	// Compare each taken frame with the oldest queued one.
	always @(posedge clk) begin : check_frames
		sbfr_pkg::frame_t want;
		if (frame_if.valid && frame_if.ready) begin
			if (pending_frames.size() == 0) begin
				$error("unexpected frame: id %02h command %02h",
					frame_if.servo_id, frame_if.command);
				errors++;
			end else begin
				want = pending_frames.pop_front();
				check_field("servo_id", want.servo_id, frame_if.servo_id);
				check_field("command", want.command, frame_if.command);
				check_field("param_count", 8'(want.param_count), 8'(frame_if.param_count));
				check_field("param0", want.param0, frame_if.param0);
				check_field("param1", want.param1, frame_if.param1);
				check_field("param2", want.param2, frame_if.param2);
				check_field("param3", want.param3, frame_if.param3);
				check_field("checksum_ok", 8'(want.checksum_ok), 8'(frame_if.checksum_ok));
				frames_checked++;
				if (!want.checksum_ok)
					bad_sum_frames++;
			end
		end
	end

	// Shortest and longest frames, with all-zero and all-one fields.
	task automatic test_field_extremes();
		send_frame(8'h00, sbfr_pkg::LEN_MIN, 8'h00, '0, 1'b0);
		send_frame(8'hFF, sbfr_pkg::LEN_MAX, 8'hFF, {4{8'hFF}}, 1'b0);
		drain_results();
	endtask

	// Half header broken by another byte, then a third 0x55 taken as the id.
	task automatic test_header_hunt();
		send_byte(sbfr_pkg::HDR_BYTE);
		send_byte(8'h12);
		send_frame(sbfr_pkg::HDR_BYTE, sbfr_pkg::LEN_MIN, 8'h5A, '0, 1'b0);
		drain_results();
	endtask

	// Length just below and just above the legal range: no frame, hunt restarts.
	task automatic test_bad_length();
		send_frame(8'h01, sbfr_pkg::LEN_MIN - 8'd1, 8'h00, '0, 1'b0);
		send_frame(8'h02, sbfr_pkg::LEN_MAX + 8'd1, 8'h00, '0, 1'b0);
		send_frame(8'h03, sbfr_pkg::LEN_MIN + 8'd1, 8'hA5,
			{8'h00, 8'h00, 8'h00, 8'h3C}, 1'b0);
		drain_results();
	endtask

	// Wrong checksum byte still yields a frame, flagged bad.
	task automatic test_bad_checksum();
		send_frame(8'h10, sbfr_pkg::LEN_MIN + 8'd1, 8'h20,
			{8'h00, 8'h00, 8'h00, 8'h30}, 1'b1);
		drain_results();
	endtask

	// Full rate both ways, then full-rate source into a stalling sink.
	task automatic test_back_to_back();
		int n;
		src_gaps    = 1'b0;
		sink_stalls = 1'b0;
		for (n = 0; n < 8; n++)
			send_random_frame(1'b1);
		sink_stalls = 1'b1;
		for (n = 0; n < 8; n++)
			send_random_frame(1'b1);
		drain_results();
		src_gaps = 1'b1;
	endtask

	// Mostly legal frames with random content; the rest bad lengths, broken
	// headers and loose noise, until the byte budget for the run is spent.
	task automatic test_random_frames();
		int frames;
		int r;
		int n;
		frames = 0;
		while (bytes_sent < 1100) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_random_frame(1'b1);
			end else if (r < 80) begin
				send_random_frame(1'b0);
			end else if (r < 90) begin
				send_byte(sbfr_pkg::HDR_BYTE);
				send_byte(8'($urandom_range(0, sbfr_pkg::HDR_BYTE - 1)));
				send_random_frame(1'b1);
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) send_byte(8'($urandom));
			end
			frames++;
			// switch idling on and off so some stretches run at full rate
			if (frames % 30 == 0) begin
				src_gaps    = $urandom_range(0, 3) != 0;
				sink_stalls = $urandom_range(0, 3) != 0;
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		rx_if.valid    = 1'b0;
		rx_if.rx_byte  = '0;
		frame_if.ready = 1'b0;
		hunt_half      = 1'b0;
		collecting     = 1'b0;
		pos            = '0;
		flen           = '0;
		h_id           = '0;
		h_cmd          = '0;
		h_sum          = '0;
		h_prm          = '0;
		src_gaps       = 1'b1;
		sink_stalls    = 1'b1;
		stall_left     = 0;
		errors         = 0;
		bytes_sent     = 0;
		frames_checked = 0;
		bad_sum_frames = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_header_hunt();
		test_bad_length();
		test_bad_checksum();
		test_back_to_back();
		test_random_frames();

		rx_if.valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d bytes; checked %0d frames, %0d of them with a bad checksum.",
			bytes_sent, frames_checked, bad_sum_frames);
		$display("Covered header hunting, bad lengths, frame lengths 3..7 and stalls.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Run limit: far above the slowest legal run.
	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
